FILE: src/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// Shared widths, operation codes and status codes for the rational
// arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

  // operand width actually used; input fields are sign-extended from its top bit
  localparam int DATA_WIDTH = 32;
  // magnitude width of the cross products and of the reduction datapath
  localparam int MAG_W      = 2 * DATA_WIDTH;
  // width of the fixed stream fields
  localparam int FIELD_W    = 32;
  localparam int ACT_W      = 2;
  localparam int STAT_W     = 2;
  // shift count width for the binary GCD
  localparam int KW         = $clog2(MAG_W);
  // iteration count width for the restoring divider
  localparam int CW         = $clog2(MAG_W);

  localparam logic [ACT_W-1:0] ACT_ADD = 2'd0;
  localparam logic [ACT_W-1:0] ACT_SUB = 2'd1;
  localparam logic [ACT_W-1:0] ACT_MUL = 2'd2;
  localparam logic [ACT_W-1:0] ACT_DIV = 2'd3;

  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_ZERO_DEN = 2'd1;
  localparam logic [STAT_W-1:0] STAT_OVERFLOW = 2'd2;

  typedef logic [MAG_W-1:0]      mag_t;
  typedef logic [DATA_WIDTH-1:0] opnd_t;

endpackage

FILE: src/rau_gcd.sv
// ----------------------------------------------------------------------------
// rau_gcd
// Binary (Stein) greatest common divisor of two nonzero magnitudes.
// One shift or one subtract per cycle.
// ----------------------------------------------------------------------------
module rau_gcd
  import rau_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  mag_t          a,
  input  mag_t          b,
  output logic          done,
  output mag_t          g
);

  logic          busy;
  mag_t          x;
  mag_t          y;
  logic [KW-1:0] k;
  logic [MAG_W:0] diff;

  assign diff = {1'b0, x} - {1'b0, y};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        x    <= a;
        y    <= b;
        k    <= '0;
      end else if (busy) begin
        if (diff == '0) begin
          // restore the common power of two
          g    <= x << k;
          done <= 1'b1;
          busy <= 1'b0;
        end else if (!x[0] && !y[0]) begin
          x <= x >> 1;
          y <= y >> 1;
          k <= k + KW'(1);
        end else if (!x[0]) begin
          x <= x >> 1;
        end else if (!y[0]) begin
          y <= y >> 1;
        end else if (!diff[MAG_W]) begin
          x <= diff[MAG_W-1:0];
        end else begin
          y <= MAG_W'(0) - diff[MAG_W-1:0];
        end
      end
    end
  end

endmodule

FILE: src/rau_div.sv
// ----------------------------------------------------------------------------
// rau_div
// Restoring divider: two dividends over one divisor, one quotient bit of
// each per cycle.
// ----------------------------------------------------------------------------
module rau_div
  import rau_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  mag_t divisor,
  input  mag_t dvd0,
  input  mag_t dvd1,
  output logic done,
  output mag_t q0,
  output mag_t q1
);

  logic          busy;
  logic [CW-1:0] cnt;
  mag_t          dsr;
  mag_t          rem0;
  mag_t          rem1;
  logic [MAG_W:0] trial0;
  logic [MAG_W:0] trial1;
  logic [MAG_W:0] sub0;
  logic [MAG_W:0] sub1;
  logic           ge0;
  logic           ge1;

  always_comb begin
    trial0 = {rem0, q0[MAG_W-1]};
    trial1 = {rem1, q1[MAG_W-1]};
    sub0   = trial0 - {1'b0, dsr};
    sub1   = trial1 - {1'b0, dsr};
    ge0    = (trial0 >= {1'b0, dsr});
    ge1    = (trial1 >= {1'b0, dsr});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(MAG_W - 1);
        dsr  <= divisor;
        rem0 <= '0;
        rem1 <= '0;
        q0   <= dvd0;
        q1   <= dvd1;
      end else if (busy) begin
        // shift quotient bits in where dividend bits leave
        rem0 <= ge0 ? sub0[MAG_W-1:0] : trial0[MAG_W-1:0];
        rem1 <= ge1 ? sub1[MAG_W-1:0] : trial1[MAG_W-1:0];
        q0   <= {q0[MAG_W-2:0], ge0};
        q1   <= {q1[MAG_W-2:0], ge1};
        cnt  <= cnt - CW'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: src/rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Adds, subtracts, multiplies or divides two fractions and reduces the
// result by the GCD of its magnitudes.
//
//   channel  dir  tdata fields (low bit up)                         width
//   s_*      in   action, num_a, den_a, num_b, den_b                130 -> 136
//   m_*      out  num_out, den_out, status                          66 -> 72
//
// A word whose result is a special case (zero denominator or zero numerator)
// skips the GCD and the divide. Otherwise the sequencer waits on the binary
// GCD loop, one shift or subtract a cycle, and then on the 64-step restoring
// divider that numerator and denominator share; these two loops set how long
// a word takes. Cross products come in turn from one shared 32x32 multiplier.
// rst clears the sequencer and the output valid. A stalled result holds in the
// output register while the next word is accepted and worked; that word waits
// at the end for it.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit
  import rau_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // action[1:0], num_a[33:2], den_a[65:34], num_b[97:66], den_b[129:98]
  input  logic [135:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // num_out[31:0], den_out[63:32], status[65:64]
  output logic [71:0]  m_tdata
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_ADD  = 3'd2;
  localparam logic [2:0] S_CHK  = 3'd3;
  localparam logic [2:0] S_GCD  = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_FIT  = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  localparam mag_t HALF = MAG_W'(1) << (DATA_WIDTH - 1);

  logic [2:0]       state;
  logic [1:0]       step;
  logic [ACT_W-1:0] act;
  opnd_t            na_mag, da_mag, nb_mag, db_mag;
  logic             na_neg, da_neg, nb_neg, db_neg;

  mag_t p_mag, q_mag, n_mag, d_mag;
  logic p_neg, q_neg, n_neg, d_neg;

  logic [FIELD_W-1:0] res_num, res_den;
  logic [STAT_W-1:0]  res_stat;

  opnd_t mx, my;
  logic  msx, msy;
  mag_t  prod;

  logic  pe_neg, qe_neg;
  logic [MAG_W:0] pq_diff;
  mag_t  pq_sum;

  logic  gcd_start, gcd_done;
  mag_t  gcd_g;
  logic  div_start, div_done;
  mag_t  div_q0, div_q1;

  logic signed [DATA_WIDTH-1:0] n_enc, d_enc;
  logic  n_fit, d_fit;

  // sign-magnitude view of an input field
  function automatic opnd_t fmag(input logic [FIELD_W-1:0] raw);
    opnd_t v;
    v = raw[DATA_WIDTH-1:0];
    return v[DATA_WIDTH-1] ? (DATA_WIDTH'(0) - v) : v;
  endfunction

  assign s_tready = (state == S_IDLE);

  // shared multiplier operand select
  always_comb begin
    mx  = na_mag;
    msx = na_neg;
    my  = db_mag;
    msy = db_neg;
    case (step)
      2'd0: begin
        mx  = na_mag;
        msx = na_neg;
        my  = (act == ACT_MUL) ? nb_mag : db_mag;
        msy = (act == ACT_MUL) ? nb_neg : db_neg;
      end
      2'd1: begin
        mx  = da_mag;
        msx = da_neg;
        my  = nb_mag;
        msy = nb_neg;
      end
      default: begin
        mx  = da_mag;
        msx = da_neg;
        my  = (act == ACT_DIV) ? nb_mag : db_mag;
        msy = (act == ACT_DIV) ? nb_neg : db_neg;
      end
    endcase
    prod = MAG_W'(mx) * MAG_W'(my);
  end

  // signed magnitude add of the two cross products
  always_comb begin
    pe_neg  = p_neg && (p_mag != '0);
    qe_neg  = (q_neg && (q_mag != '0)) ^ ((act == ACT_SUB) && (q_mag != '0));
    pq_diff = {1'b0, p_mag} - {1'b0, q_mag};
    pq_sum  = p_mag + q_mag;
  end

  assign gcd_start = (state == S_CHK) && (d_mag != '0) && (n_mag != '0);
  assign div_start = (state == S_GCD) && gcd_done;

  rau_gcd u_gcd (
    .clk   (clk),
    .rst   (rst),
    .start (gcd_start),
    .a     (n_mag),
    .b     (d_mag),
    .done  (gcd_done),
    .g     (gcd_g)
  );

  rau_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .divisor (gcd_g),
    .dvd0    (n_mag),
    .dvd1    (d_mag),
    .done    (div_done),
    .q0      (div_q0),
    .q1      (div_q1)
  );

  always_comb begin
    n_fit = n_neg ? (div_q0 <= HALF) : (div_q0 < HALF);
    d_fit = d_neg ? (div_q1 <= HALF) : (div_q1 < HALF);
    n_enc = n_neg ? (DATA_WIDTH'(0) - div_q0[DATA_WIDTH-1:0]) : div_q0[DATA_WIDTH-1:0];
    d_enc = d_neg ? (DATA_WIDTH'(0) - div_q1[DATA_WIDTH-1:0]) : div_q1[DATA_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      step     <= 2'd0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            act    <= s_tdata[1:0];
            na_mag <= fmag(s_tdata[33:2]);
            da_mag <= fmag(s_tdata[65:34]);
            nb_mag <= fmag(s_tdata[97:66]);
            db_mag <= fmag(s_tdata[129:98]);
            na_neg <= s_tdata[2 + DATA_WIDTH - 1];
            da_neg <= s_tdata[34 + DATA_WIDTH - 1];
            nb_neg <= s_tdata[66 + DATA_WIDTH - 1];
            db_neg <= s_tdata[98 + DATA_WIDTH - 1];
            step   <= 2'd0;
            state  <= S_MUL;
          end
        end
        S_MUL: begin
          case (step)
            2'd0: begin
              p_mag <= prod;
              p_neg <= msx ^ msy;
            end
            2'd1: begin
              q_mag <= prod;
              q_neg <= msx ^ msy;
            end
            default: begin
              d_mag <= prod;
              d_neg <= msx ^ msy;
            end
          endcase
          step <= step + 2'd1;
          if (step == 2'd2) begin
            state <= S_ADD;
          end
        end
        S_ADD: begin
          if (act == ACT_ADD || act == ACT_SUB) begin
            if (pe_neg == qe_neg) begin
              n_mag <= pq_sum;
              n_neg <= pe_neg;
            end else if (!pq_diff[MAG_W]) begin
              n_mag <= pq_diff[MAG_W-1:0];
              n_neg <= pe_neg;
            end else begin
              n_mag <= MAG_W'(0) - pq_diff[MAG_W-1:0];
              n_neg <= qe_neg;
            end
          end else begin
            n_mag <= p_mag;
            n_neg <= pe_neg;
          end
          state <= S_CHK;
        end
        S_CHK: begin
          if (d_mag == '0) begin
            res_num  <= '0;
            res_den  <= '0;
            res_stat <= STAT_ZERO_DEN;
            state    <= S_FIN;
          end else if (n_mag == '0) begin
            res_num  <= '0;
            res_den  <= FIELD_W'(1);
            res_stat <= STAT_OK;
            state    <= S_FIN;
          end else begin
            state <= S_GCD;
          end
        end
        S_GCD: begin
          if (gcd_done) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_FIT;
          end
        end
        S_FIT: begin
          if (n_fit && d_fit) begin
            res_num  <= FIELD_W'(n_enc);
            res_den  <= FIELD_W'(d_enc);
            res_stat <= STAT_OK;
          end else begin
            res_num  <= '0;
            res_den  <= '0;
            res_stat <= STAT_OVERFLOW;
          end
          state <= S_FIN;
        end
        S_FIN: begin
          // hold until the output register is free
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {6'd0, res_stat, res_den, res_num};
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
